// ===== rtl/core/gauss_elimination_solver_top_macros.svh =====
// Assertion macros shared by the solver RTL.
// Included by files that carry concurrent assertions; expects a clk and rst in scope.
`ifndef GAUSS_ELIMINATION_SOLVER_TOP_MACROS_SVH
`define GAUSS_ELIMINATION_SOLVER_TOP_MACROS_SVH

// Checked only while out of reset.
`define GES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define GES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ges_pkg.sv =====
// Shared constants and arithmetic helpers for the Gaussian elimination solver.
// No dependencies; used by ges_div and gauss_elimination_solver_top.
package ges_pkg;

  localparam int MAX_UNKNOWNS = 8;
  localparam int DATA_WIDTH   = 32;
  localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
  localparam int ROW_LEN      = MAX_UNKNOWNS + 1;
  localparam int MEM_DEPTH    = MAX_UNKNOWNS * ROW_LEN;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int ROW_W        = $clog2(MAX_UNKNOWNS);
  localparam int COL_W        = $clog2(ROW_LEN);
  localparam int SIZE_W       = 4;
  localparam int FRAC_BITS    = 16;

  localparam logic signed [PROD_WIDTH-1:0] WORD_MAX_WIDE =
    (PROD_WIDTH'(1) <<< (DATA_WIDTH - 1)) - PROD_WIDTH'(1);
  localparam logic signed [PROD_WIDTH-1:0] WORD_MIN_WIDE = -WORD_MAX_WIDE - PROD_WIDTH'(1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [PROD_WIDTH-1:0] wide_t;

  function automatic word_t sat_word(input wide_t v);
    if (v > WORD_MAX_WIDE) return DATA_WIDTH'(WORD_MAX_WIDE);
    if (v < WORD_MIN_WIDE) return DATA_WIDTH'(WORD_MIN_WIDE);
    return DATA_WIDTH'(v);
  endfunction

  // Division by 2^16 with truncation toward zero.
  function automatic wide_t trunc_frac(input wide_t v);
    wide_t s;
    s = v >>> FRAC_BITS;
    if (v[PROD_WIDTH-1] && (v[FRAC_BITS-1:0] != '0)) s = s + PROD_WIDTH'(1);
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * ROW_LEN + int'(c));
  endfunction

endpackage

// ===== rtl/core/ges_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ges_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ges_div.sv =====
// Bit-serial signed divider: wide dividend over word divisor, truncating toward zero,
// quotient saturated to the word range. Depends on ges_pkg.
module ges_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ges_pkg::wide_t    dividend,
  input  ges_pkg::word_t    divisor,
  output logic              done,
  output ges_pkg::word_t    quotient
);

  localparam int PW = ges_pkg::PROD_WIDTH;
  localparam int DW = ges_pkg::DATA_WIDTH;

  logic          busy;
  logic [$clog2(PW)-1:0] cnt;
  logic [PW-1:0] dq;
  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic          neg;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem, dq[PW-1]};
  assign fits   = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend[PW-1] ? PW'(-dividend) : PW'(dividend);
        dv   <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
        neg  <= dividend[PW-1] ^ divisor[DW-1];
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? DW'(rem_sh - {1'b0, dv}) : DW'(rem_sh);
        dq  <= {dq[PW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(PW)'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (!neg) begin
      quotient = ges_pkg::sat_word(ges_pkg::wide_t'({1'b0, dq[PW-2:0]}));
      if (dq[PW-1]) quotient = DW'(ges_pkg::WORD_MAX_WIDE);
    end else begin
      quotient = ges_pkg::sat_word(-ges_pkg::wide_t'({1'b0, dq[PW-2:0]}));
      if (dq[PW-1]) quotient = DW'(ges_pkg::WORD_MIN_WIDE);
    end
  end

endmodule

// ===== rtl/core/gauss_elimination_solver_top.sv =====
// Gaussian elimination solver, top level: load sequencer, elimination and back substitution.
// Depends on ges_pkg, ges_ram, ges_div and gauss_elimination_solver_top_macros.svh.
//
//   channel   direction  handshake                        payload
//   in        input      in_valid / in_ready              coefficient
//   out       output     out_valid / out_ready            solution_value, unknown_index,
//                                                         singular_flag, last_of_run
//   cfg       input      cfg_write_enable                 cfg_write_data (system_size)
//
// The final word starts the solve, which runs on the single-write, single-read matrix RAM and
// a bit-serial divider: elimination, then back substitution, then n result words.
// Input is held off during the solve, while results wait and while the size register is
// written; rst is synchronous.
`include "gauss_elimination_solver_top_macros.svh"
module gauss_elimination_solver_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ges_pkg::word_t                    coefficient,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ges_pkg::word_t                    solution_value,
  output logic [ges_pkg::ROW_W-1:0]         unknown_index,
  output logic                              singular_flag,
  output logic                              last_of_run,
  input  logic                              cfg_write_enable,
  input  logic [ges_pkg::SIZE_W-1:0]        cfg_write_data
);

  typedef enum logic [15:0] {
    ST_LOAD   = 16'b0000_0000_0000_0001,
    ST_E_RDP  = 16'b0000_0000_0000_0010,
    ST_E_RDT  = 16'b0000_0000_0000_0100,
    ST_E_CHK  = 16'b0000_0000_0000_1000,
    ST_E_RDJK = 16'b0000_0000_0001_0000,
    ST_E_MUL  = 16'b0000_0000_0010_0000,
    ST_E_DGO  = 16'b0000_0000_0100_0000,
    ST_E_DIVW = 16'b0000_0000_1000_0000,
    ST_E_UPD  = 16'b0000_0001_0000_0000,
    ST_B_RD   = 16'b0000_0010_0000_0000,
    ST_B_MUL  = 16'b0000_0100_0000_0000,
    ST_B_ACC  = 16'b0000_1000_0000_0000,
    ST_B_NUM  = 16'b0001_0000_0000_0000,
    ST_B_PIV  = 16'b0010_0000_0000_0000,
    ST_B_DIVW = 16'b0100_0000_0000_0000,
    ST_EMIT   = 16'b1000_0000_0000_0000
  } state_t;

  localparam int RW = ges_pkg::ROW_W;
  localparam int CW = ges_pkg::COL_W;
  localparam int SW = ges_pkg::SIZE_W;
  localparam int DW = ges_pkg::DATA_WIDTH;

  state_t                     state;
  logic [SW-1:0]              system_size;
  logic [SW-1:0]              n_eff;
  logic [RW-1:0]              n_m1;
  logic [RW-1:0]              lrow;
  logic [CW-1:0]              lcol;
  logic [RW-1:0]              ri;
  logic [CW-1:0]              rj;
  logic [CW-1:0]              rk;
  ges_pkg::word_t             piv;
  ges_pkg::word_t             tval;
  ges_pkg::word_t             qval;
  ges_pkg::word_t             num;
  ges_pkg::wide_t             prod;
  ges_pkg::wide_t             acc;
  ges_pkg::word_t             xs [ges_pkg::MAX_UNKNOWNS];
  logic                       sing;
  logic [RW-1:0]              oidx;

  logic                       ram_we;
  logic [ges_pkg::ADDR_W-1:0] ram_waddr;
  logic [ges_pkg::ADDR_W-1:0] ram_raddr;
  logic [DW-1:0]              ram_wdata;
  logic [DW-1:0]              ram_rdata;
  ges_pkg::word_t             word_s;

  logic                       div_start;
  ges_pkg::wide_t             div_dividend;
  ges_pkg::word_t             div_divisor;
  logic                       div_done;
  ges_pkg::word_t             div_q;
  logic                       in_acc;

  assign word_s = signed'(ram_rdata);
  assign n_eff  = (system_size == '0) ? SW'(1) :
                  (system_size > SW'(ges_pkg::MAX_UNKNOWNS)) ? SW'(ges_pkg::MAX_UNKNOWNS) :
                  system_size;
  assign n_m1   = RW'(n_eff - SW'(1));
  // A size write restarts the load, so no word is taken in that cycle.
  assign in_ready = (state == ST_LOAD) && !cfg_write_enable;
  assign in_acc   = in_valid && in_ready;

  ges_ram #(.WIDTH(DW), .DEPTH(ges_pkg::MEM_DEPTH)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ges_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (state)
      ST_E_RDP:  ram_raddr = ges_pkg::cell_addr(rj[RW-1:0], rj);
      ST_E_RDT:  ram_raddr = ges_pkg::cell_addr(ri, rj);
      ST_E_RDJK: ram_raddr = ges_pkg::cell_addr(rj[RW-1:0], rk);
      ST_E_DIVW: ram_raddr = ges_pkg::cell_addr(ri, rk);
      ST_B_RD:   ram_raddr = (rj < n_eff) ? ges_pkg::cell_addr(ri, rj)
                                          : ges_pkg::cell_addr(ri, n_eff);
      ST_B_NUM:  ram_raddr = ges_pkg::cell_addr(ri, CW'(ri));
      default:   ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ges_pkg::cell_addr(lrow, lcol);
    ram_wdata = coefficient;
    if (state == ST_LOAD) begin
      ram_we = in_acc;
    end else if (state == ST_E_UPD) begin
      ram_we    = 1'b1;
      ram_waddr = ges_pkg::cell_addr(ri, rk);
      ram_wdata = ges_pkg::sat_word(ges_pkg::wide_t'(word_s) - ges_pkg::wide_t'(qval));
    end
  end

  // The back-substitution pivot is taken straight from the RAM read.
  assign div_start    = (state == ST_E_DGO) || ((state == ST_B_PIV) && (word_s != '0));
  assign div_dividend = (state == ST_B_PIV) ? (ges_pkg::wide_t'(num) <<< ges_pkg::FRAC_BITS)
                                            : prod;
  assign div_divisor  = (state == ST_B_PIV) ? word_s : piv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      system_size <= SW'(2);
      lrow        <= '0;
      lcol        <= '0;
      sing        <= 1'b0;
      oidx        <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (cfg_write_enable) begin
            system_size <= cfg_write_data;
            lrow        <= '0;
            lcol        <= '0;
          end else if (in_acc) begin
            if (lcol == n_eff) begin
              lcol <= '0;
              lrow <= lrow + 1'b1;
            end else begin
              lcol <= lcol + 1'b1;
            end
            if ((lrow == n_m1) && (lcol == n_eff)) begin
              lrow <= '0;
              sing <= 1'b0;
              if (n_eff == SW'(1)) begin
                ri    <= n_m1;
                rj    <= n_eff;
                acc   <= '0;
                state <= ST_B_RD;
              end else begin
                ri    <= RW'(1);
                rj    <= '0;
                state <= ST_E_RDP;
              end
            end
          end
        end
        ST_E_RDP:  state <= ST_E_RDT;
        ST_E_RDT: begin
          piv   <= word_s;
          state <= ST_E_CHK;
        end
        ST_E_CHK: begin
          tval <= word_s;
          rk   <= rj + 1'b1;
          if (piv == '0) begin
            sing  <= 1'b1;
            oidx  <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_E_RDJK;
          end
        end
        ST_E_RDJK: state <= ST_E_MUL;
        ST_E_MUL: begin
          prod  <= word_s * tval;
          state <= ST_E_DGO;
        end
        ST_E_DGO:  state <= ST_E_DIVW;
        ST_E_DIVW: begin
          if (div_done) begin
            qval  <= div_q;
            state <= ST_E_UPD;
          end
        end
        ST_E_UPD: begin
          if (rk == n_eff) begin
            if ((rj + 1'b1) < CW'(ri)) begin
              rj    <= rj + 1'b1;
              state <= ST_E_RDP;
            end else if (ri < n_m1) begin
              ri    <= ri + 1'b1;
              rj    <= '0;
              state <= ST_E_RDP;
            end else begin
              ri    <= n_m1;
              rj    <= n_eff;
              acc   <= '0;
              state <= ST_B_RD;
            end
          end else begin
            rk    <= rk + 1'b1;
            state <= ST_E_RDJK;
          end
        end
        ST_B_RD:   state <= (rj < n_eff) ? ST_B_MUL : ST_B_NUM;
        ST_B_MUL: begin
          prod  <= word_s * xs[rj[RW-1:0]];
          state <= ST_B_ACC;
        end
        ST_B_ACC: begin
          acc   <= acc + ges_pkg::trunc_frac(prod);
          rj    <= rj + 1'b1;
          state <= ST_B_RD;
        end
        ST_B_NUM: begin
          num   <= ges_pkg::sat_word(ges_pkg::wide_t'(word_s) - acc);
          state <= ST_B_PIV;
        end
        ST_B_PIV: begin
          if (word_s == '0) begin
            sing  <= 1'b1;
            oidx  <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_B_DIVW;
          end
        end
        ST_B_DIVW: begin
          if (div_done) begin
            xs[ri] <= div_q;
            if (ri == '0) begin
              oidx  <= '0;
              state <= ST_EMIT;
            end else begin
              ri    <= ri - 1'b1;
              rj    <= CW'(ri);
              acc   <= '0;
              state <= ST_B_RD;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            oidx <= oidx + 1'b1;
            if (oidx == n_m1) begin
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign out_valid      = (state == ST_EMIT);
  assign solution_value = sing ? '0 : xs[oidx];
  assign unknown_index  = oidx;
  assign singular_flag  = sing;
  assign last_of_run    = (oidx == n_m1);

  `GES_ASSERT_ALWAYS(a_sides_exclusive, rst || !(in_ready && out_valid), "input and output both open")
  `GES_ASSERT(a_div_nonzero, div_start |-> (div_divisor != '0), "divider started on zero")
  `GES_ASSERT(a_last_reopens, (out_valid && out_ready && last_of_run) |=> (in_ready || cfg_write_enable), "load did not resume after last word")
  `GES_ASSERT(a_singular_zero, (out_valid && singular_flag) |-> (solution_value == '0), "singular run emitted a nonzero value")

endmodule
